FILE: rtl/core/fra_pkg.sv
// fra_pkg: shared types and constants for the fraction arithmetic block
// used by fra_mul, fra_div and fraction_arith_reduce; no dependencies
package fra_pkg;

  localparam int OPERAND_WIDTH_DEF = 16;

  typedef enum logic [1:0] {
    CMD_ADD = 2'd0,
    CMD_SUB = 2'd1,
    CMD_MUL = 2'd2,
    CMD_DIV = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_MUL_C,
    ST_SUM,
    ST_GCD_CHECK,
    ST_GCD_WAIT,
    ST_DIVN_WAIT,
    ST_DIVD_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

FILE: rtl/core/fra_mul.sv
// fra_mul: shared unsigned magnitude multiplier with registered product
// depends on fra_pkg for the default operand width
module fra_mul #(
  parameter int W = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic             clk,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [2*W-1:0]   prod
);
  import fra_pkg::*;

  always_ff @(posedge clk) begin
    prod <= a * b;
  end

endmodule

FILE: rtl/core/fra_div.sv
// fra_div: iterative restoring divider, one quotient bit per cycle
// depends on fra_pkg for the default width and the status struct
module fra_div #(
  parameter int DW = 2 * fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                go,
  input  logic [DW-1:0]       dividend,
  input  logic [DW-1:0]       divisor,
  output logic [DW-1:0]       quotient,
  output logic [DW-1:0]       remainder,
  output fra_pkg::div_stat_t  stat
);
  import fra_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] quo_sh;
  logic [DW-1:0] rem;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;

  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          fits;
  logic [DW-1:0] rem_next;

  always_comb begin
    trial    = {rem, quo_sh[DW-1]};
    diff     = trial - {1'b0, dvs};
    fits     = trial >= {1'b0, dvs};
    rem_next = fits ? diff[DW-1:0] : trial[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      quo_sh <= dividend;
      rem    <= '0;
      dvs    <= divisor;
    end else if (busy) begin
      quo_sh <= {quo_sh[DW-2:0], fits};
      rem    <= rem_next;
    end
  end

  assign quotient  = quo_sh;
  assign remainder = rem;
  assign stat      = '{busy: busy, done: done};

endmodule

FILE: rtl/core/fraction_arith_reduce.sv
// fraction_arith_reduce: add, subtract, multiply or divide two signed fractions
// and reduce the result by its greatest common divisor
// depends on fra_pkg, fra_mul and fra_div
//
// usage
//   input channel (in_valid/in_ready) takes cmd and the four operands; in_ready
//   is high only while the sequencer is idle, so one item is worked at a time
//   output channel (out_valid/out_ready) gives reduced_num, reduced_den,
//   is_whole and error from an output register
//   an item with a zero operand goes from idle straight to the finish state;
//   otherwise it passes through the three multiply states, the sum state, the
//   gcd loop of remainder steps and the two final divisions
//   the one shared restoring divider makes one quotient bit per cycle and
//   serves every gcd step and both final divisions; the three cross products
//   are formed one after another on one shared multiplier
//   a finished result waits in the finish state while out_valid is high and
//   out_ready is low; the next item is taken once the result is loaded
//   reset clears the sequencer, the divider control and out_valid
module fraction_arith_reduce #(
  parameter int OPERAND_WIDTH = fra_pkg::OPERAND_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [1:0]                      cmd,
  input  logic signed [OPERAND_WIDTH-1:0] first_num,
  input  logic signed [OPERAND_WIDTH-1:0] first_den,
  input  logic signed [OPERAND_WIDTH-1:0] second_num,
  input  logic signed [OPERAND_WIDTH-1:0] second_den,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [2*OPERAND_WIDTH:0] reduced_num,
  output logic [2*OPERAND_WIDTH-2:0]      reduced_den,
  output logic                            is_whole,
  output logic                            error
);
  import fra_pkg::*;

  localparam int W  = OPERAND_WIDTH;
  localparam int PW = 2 * W;
  localparam int DN = 2 * W - 1;
  localparam int NW = 2 * W + 1;

  state_t state, state_next;

  // captured operands
  cmd_t          cmd_q;
  logic [W-1:0]  n1_mag, d1_mag, n2_mag, d2_mag;
  logic          n1_neg, d1_neg, n2_neg, d2_neg;
  logic          err_q;

  // working values
  logic [PW-1:0] t1;
  logic [DN-1:0] den_mag;
  logic [PW-1:0] num_mag;
  logic          num_neg;
  logic [PW-1:0] gcd_a, gcd_b;

  // shared units
  logic [W-1:0]  mul_a, mul_b;
  logic [PW-1:0] prod;
  logic          div_go;
  logic [PW-1:0] div_dvd, div_dvs;
  logic [PW-1:0] div_quo, div_rem;
  div_stat_t     div_stat;

  logic          accept;
  logic          load_out;

  // input decode
  logic [W-1:0]  in_n1, in_d1, in_n2, in_d2;
  logic          in_zero;

  // sum stage
  logic          sum_mode;
  logic          s1, s2, s_den;
  logic [PW-1:0] sum_mag;
  logic          sum_neg;
  logic          fin_neg;

  logic [NW-1:0] nm_ext;
  logic [NW-1:0] num_out;

  fra_mul #(.W(W)) u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  fra_div #(.DW(PW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .go        (div_go),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .quotient  (div_quo),
    .remainder (div_rem),
    .stat      (div_stat)
  );

  always_comb begin
    in_n1   = first_num[W-1]  ? (~first_num + 1'b1)  : first_num;
    in_d1   = first_den[W-1]  ? (~first_den + 1'b1)  : first_den;
    in_n2   = second_num[W-1] ? (~second_num + 1'b1) : second_num;
    in_d2   = second_den[W-1] ? (~second_den + 1'b1) : second_den;
    in_zero = (first_num == '0) || (first_den == '0) ||
              (second_num == '0) || (second_den == '0);
  end

  assign accept = in_valid && in_ready;

  // signs of the cross products and their signed sum
  always_comb begin
    sum_mode = (cmd_q == CMD_ADD) || (cmd_q == CMD_SUB);
    s1       = n1_neg ^ ((cmd_q == CMD_MUL) ? n2_neg : d2_neg);
    s2       = n2_neg ^ d1_neg ^ (cmd_q == CMD_SUB);
    s_den    = d1_neg ^ ((cmd_q == CMD_DIV) ? n2_neg : d2_neg);
    if (!sum_mode) begin
      sum_mag = t1;
      sum_neg = s1;
    end else if (s1 == s2) begin
      sum_mag = t1 + prod;
      sum_neg = s1;
    end else if (t1 >= prod) begin
      sum_mag = t1 - prod;
      sum_neg = s1;
    end else begin
      sum_mag = prod - t1;
      sum_neg = s2;
    end
    fin_neg = (sum_neg ^ s_den) && (sum_mag != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_a      = n2_mag;
    mul_b      = d1_mag;
    div_go     = 1'b0;
    div_dvd    = gcd_a;
    div_dvs    = gcd_b;
    load_out   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_next = in_zero ? ST_FINISH : ST_MUL_A;
        end
      end
      ST_MUL_A: begin
        mul_a      = n1_mag;
        mul_b      = (cmd_q == CMD_MUL) ? n2_mag : d2_mag;
        state_next = ST_MUL_B;
      end
      ST_MUL_B: begin
        mul_a      = d1_mag;
        mul_b      = (cmd_q == CMD_DIV) ? n2_mag : d2_mag;
        state_next = ST_MUL_C;
      end
      ST_MUL_C: begin
        state_next = ST_SUM;
      end
      ST_SUM: begin
        state_next = ST_GCD_CHECK;
      end
      ST_GCD_CHECK: begin
        div_go = 1'b1;
        if (gcd_b == '0) begin
          div_dvd    = num_mag;
          div_dvs    = gcd_a;
          state_next = ST_DIVN_WAIT;
        end else begin
          state_next = ST_GCD_WAIT;
        end
      end
      ST_GCD_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_GCD_CHECK;
        end
      end
      ST_DIVN_WAIT: begin
        div_dvd = {1'b0, den_mag};
        div_dvs = gcd_a;
        if (div_stat.done) begin
          div_go     = 1'b1;
          state_next = ST_DIVD_WAIT;
        end
      end
      ST_DIVD_WAIT: begin
        if (div_stat.done) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (!out_valid || out_ready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q  <= cmd_t'(cmd);
      n1_mag <= in_n1;
      d1_mag <= in_d1;
      n2_mag <= in_n2;
      d2_mag <= in_d2;
      n1_neg <= first_num[W-1];
      d1_neg <= first_den[W-1];
      n2_neg <= second_num[W-1];
      d2_neg <= second_den[W-1];
      err_q  <= in_zero;
    end
    if (state == ST_MUL_B) begin
      t1 <= prod;
    end
    if (state == ST_MUL_C) begin
      den_mag <= prod[DN-1:0];
    end
    if (state == ST_SUM) begin
      num_mag <= sum_mag;
      num_neg <= fin_neg;
      gcd_a   <= sum_mag;
      gcd_b   <= {1'b0, den_mag};
    end
    if (state == ST_GCD_WAIT && div_stat.done) begin
      gcd_a <= gcd_b;
      gcd_b <= div_rem;
    end
    if (state == ST_DIVN_WAIT && div_stat.done) begin
      num_mag <= div_quo;
    end
    if (state == ST_DIVD_WAIT && div_stat.done) begin
      den_mag <= div_quo[DN-1:0];
    end
  end

  always_comb begin
    nm_ext  = {1'b0, num_mag};
    num_out = num_neg ? (~nm_ext + 1'b1) : nm_ext;
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      error <= err_q;
      if (err_q) begin
        reduced_num <= '0;
        reduced_den <= '0;
        is_whole    <= 1'b0;
      end else begin
        reduced_num <= $signed(num_out);
        reduced_den <= den_mag;
        is_whole    <= den_mag == DN'(1);
      end
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("block ready again right after taking an item");

  a_error_zero_den: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> reduced_den == '0 && reduced_num == '0)
    else $error("error result carries nonzero fields");

  a_den_positive: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> reduced_den != '0)
    else $error("reduced denominator is zero without error");

  a_whole_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid && !error |-> is_whole == (reduced_den == DN'(1)))
    else $error("is_whole does not match reduced denominator");

endmodule
